/* src/prc_pkg.sv */
// Shared constants and register codes for the roll correction PID core.
package prc_pkg;

    // Field widths of the stream and configuration ports.
    localparam int ANGLE_W    = 17;
    localparam int ELAPSED_W  = 8;
    localparam int CORR_W     = 16;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int MAXC_W     = 7;
    localparam int NOM_W      = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath sizes: the shared accumulator, the multiplier shift register,
    // the step counter, the number of quotient bits and the error difference.
    localparam int ACC_W     = 64;
    localparam int MQ_W      = 24;
    localparam int CNT_W     = 5;
    localparam int DIV_STEPS = 15;
    localparam int DIFF_W    = 18;

    // Default width of the saturating integral.
    localparam int DEFAULT_INTEGRAL_WIDTH = 48;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_CORR    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_NOM_INTERVAL = 3'd4;

    // Register values after reset.
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN    = 16'd8;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN   = 16'd1;
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN   = 16'd3500;
    localparam logic [MAXC_W-1:0] RST_MAX_CORR     = 7'd45;
    localparam logic [NOM_W-1:0]  RST_NOM_INTERVAL = 8'd4;

    // Accumulator clamp. Anything at this magnitude is far past the largest
    // possible output bound, so clamping there never changes a result.
    localparam logic signed [ACC_W-1:0] SAT_POS = 64'sh1000_0000_0000_0000;
    localparam logic signed [ACC_W-1:0] SAT_NEG = -SAT_POS;

    // Error limits: the most negative angle would give an error one past
    // the 17 bit range, so it is pinned to the largest positive error.
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 17'sh10000;
    localparam logic signed [ANGLE_W-1:0] ERR_MAX   = 17'sh0FFFF;

endpackage

/* src/pid_roll_correction_core.sv */
// Roll correction PID controller built around one shared add/subtract unit.
//
// The slave stream carries one attitude sample per beat: s_tdata holds the
// roll angle (signed Q9.8 degrees) and the time elapsed since the previous
// sample. The master stream returns one signed Q8.8 correction per sample.
// Gains, the correction limit and the nominal interval are written through
// the cfg_* port; the user must do so while the core is idle (not enforced).
//
// A single 64 bit adder with a clamp does all the arithmetic. Products are
// formed one multiplier bit per cycle, most significant bit first, and the
// final scaling is a restoring divide giving one quotient bit per cycle.
// A sample runs through all steps before the next is accepted; when the
// output saturates, the divide is skipped and the limit is registered.
// s_tready is high only while the sequencer is idle.
//
// Reset restores the register defaults, clears the integral, the previous
// error and the first sample flag. When the receiver stalls, the finished
// result waits in the output register and the core holds its last step
// until that beat is taken; a new sample can still be accepted while an
// older result waits.
module pid_roll_correction_core
    import prc_pkg::*;
#(
    parameter int INTEGRAL_WIDTH = DEFAULT_INTEGRAL_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Sample input: [16:0] roll_angle, [24:17] elapsed, [31:25] zero.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    // Correction output: [15:0] correction.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IW = INTEGRAL_WIDTH;
    localparam logic signed [IW-1:0] INT_MAX = {1'b0, {(IW-1){1'b1}}};
    localparam logic signed [IW-1:0] INT_MIN = {1'b1, {(IW-1){1'b0}}};

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_INTEG = 4'd2;
    localparam logic [3:0] ST_IGAIN = 4'd3;
    localparam logic [3:0] ST_ITERM = 4'd4;
    localparam logic [3:0] ST_ADDI  = 4'd5;
    localparam logic [3:0] ST_ADDD  = 4'd6;
    localparam logic [3:0] ST_PN    = 4'd7;
    localparam logic [3:0] ST_GP    = 4'd8;
    localparam logic [3:0] ST_GD    = 4'd9;
    localparam logic [3:0] ST_THR   = 4'd10;
    localparam logic [3:0] ST_ABS   = 4'd11;
    localparam logic [3:0] ST_CMP   = 4'd12;
    localparam logic [3:0] ST_DIV   = 4'd13;
    localparam logic [3:0] ST_OUT   = 4'd14;

    // Configuration registers.
    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] integ_gain_reg;
    logic [GAIN_W-1:0] deriv_gain_reg;
    logic [MAXC_W-1:0] max_corr_reg;
    logic [NOM_W-1:0]  nom_interval_reg;

    // Sequencer and datapath registers.
    logic [3:0]                state_reg, state_next;
    logic [3:0]                ret_reg, ret_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   mcand_reg, mcand_next;
    logic [MQ_W-1:0]           mplier_reg, mplier_next;
    logic signed [ACC_W-1:0]   p_reg, p_next;
    logic signed [ACC_W-1:0]   pn_reg, pn_next;
    logic                      neg_reg, neg_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic [ELAPSED_W-1:0]      dt_reg, dt_next;
    logic signed [IW-1:0]      integ_sum_reg, integ_sum_next;
    logic signed [ANGLE_W-1:0] prev_err_reg, prev_err_next;
    logic                      started_reg, started_next;
    logic                      out_valid_reg, out_valid_next;
    logic [CORR_W-1:0]         out_data_reg, out_data_next;

    // Shared arithmetic unit signals.
    logic signed [ACC_W-1:0] alu_a;
    logic signed [ACC_W-1:0] alu_b;
    logic                    alu_sub;
    logic signed [ACC_W-1:0] alu_raw;
    logic signed [ACC_W-1:0] alu_res;

    // Helper values.
    logic signed [ANGLE_W-1:0] angle;
    logic signed [ANGLE_W-1:0] err;
    logic [NOM_W-1:0]          nom;
    logic [ELAPSED_W-1:0]      dt_sel;
    logic signed [24:0]        delta;
    logic signed [IW:0]        isum_wide;
    logic signed [IW-1:0]      isum_sat;
    logic signed [ACC_W-1:0]   i_ext;
    logic signed [ACC_W-1:0]   i_clamp;
    logic                      zero_gain;
    logic [CORR_W-1:0]         q_mag;
    logic                      in_beat;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Sample decode: error, nominal interval and the interval used.
    assign angle  = s_tdata[ANGLE_W-1:0];
    assign err    = (angle == ANGLE_MIN) ? ERR_MAX : -angle;
    assign nom    = (nom_interval_reg == '0) ? NOM_W'(1) : nom_interval_reg;

    always_comb begin
        dt_sel = started_reg ? s_tdata[ANGLE_W +: ELAPSED_W] : nom;
        if (dt_sel == '0) begin
            dt_sel = ELAPSED_W'(1);
        end
    end

    // Saturating integral update with the error times interval product.
    assign delta     = acc_reg[24:0];
    assign isum_wide = (IW+1)'(integ_sum_reg) + (IW+1)'(delta);

    always_comb begin
        if (isum_wide[IW] != isum_wide[IW-1]) begin
            isum_sat = isum_wide[IW] ? INT_MIN : INT_MAX;
        end else begin
            isum_sat = isum_wide[IW-1:0];
        end
    end

    // Integral clamped to the accumulator range before it is multiplied.
    assign i_ext = ACC_W'(integ_sum_reg);

    always_comb begin
        if (i_ext > SAT_POS) begin
            i_clamp = SAT_POS;
        end else if (i_ext < SAT_NEG) begin
            i_clamp = SAT_NEG;
        end else begin
            i_clamp = i_ext;
        end
    end

    assign zero_gain = (prop_gain_reg == '0) && (integ_gain_reg == '0) &&
                       (deriv_gain_reg == '0);
    assign q_mag     = {1'b0, mplier_reg[DIV_STEPS-1:0]};

    // Operand selection for the shared adder.
    always_comb begin
        alu_a   = acc_reg;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_MUL: begin
                alu_a = acc_reg <<< 1;
                alu_b = mplier_reg[MQ_W-1] ? mcand_reg : '0;
            end
            ST_ADDI, ST_ADDD: begin
                alu_a = p_reg;
                alu_b = acc_reg;
            end
            ST_GP: begin
                alu_b = ACC_W'(prop_gain_reg);
            end
            ST_GD: begin
                alu_b = ACC_W'(deriv_gain_reg);
            end
            ST_ABS: begin
                alu_a   = '0;
                alu_b   = pn_reg;
                alu_sub = 1'b1;
            end
            ST_CMP: begin
                alu_a   = p_reg;
                alu_b   = pn_reg;
                alu_sub = 1'b1;
            end
            ST_DIV: begin
                alu_a   = pn_reg;
                alu_b   = mcand_reg;
                alu_sub = 1'b1;
            end
            default: begin
                alu_a = acc_reg;
            end
        endcase
    end

    // The adder itself, with the result clamped to the accumulator range.
    assign alu_raw = alu_a + (alu_sub ? ~alu_b : alu_b) + ACC_W'(alu_sub);

    always_comb begin
        if (alu_raw > SAT_POS) begin
            alu_res = SAT_POS;
        end else if (alu_raw < SAT_NEG) begin
            alu_res = SAT_NEG;
        end else begin
            alu_res = alu_raw;
        end
    end

    // Sequencer: each step loads the next multiply or runs one adder pass.
    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        p_next         = p_reg;
        pn_next        = pn_reg;
        neg_next       = neg_reg;
        diff_next      = diff_reg;
        dt_next        = dt_reg;
        integ_sum_next = integ_sum_reg;
        prev_err_next  = prev_err_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    diff_next     = DIFF_W'(err) - DIFF_W'(prev_err_reg);
                    prev_err_next = err;
                    started_next  = 1'b1;
                    dt_next       = dt_sel;
                    // Error times interval.
                    acc_next      = '0;
                    mcand_next    = ACC_W'(err);
                    mplier_next   = {dt_sel, 16'd0};
                    cnt_next      = CNT_W'(ELAPSED_W);
                    ret_next      = ST_INTEG;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL: begin
                acc_next    = alu_res;
                mplier_next = mplier_reg << 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ret_reg;
                end
            end
            ST_INTEG: begin
                integ_sum_next = isum_sat;
                // Proportional gain times error times interval.
                acc_next    = '0;
                mcand_next  = acc_reg;
                mplier_next = {prop_gain_reg, 8'd0};
                cnt_next    = CNT_W'(GAIN_W);
                ret_next    = ST_IGAIN;
                state_next  = ST_MUL;
            end
            ST_IGAIN: begin
                p_next      = acc_reg;
                // Integral gain times interval.
                acc_next    = '0;
                mcand_next  = ACC_W'(dt_reg);
                mplier_next = {integ_gain_reg, 8'd0};
                cnt_next    = CNT_W'(GAIN_W);
                ret_next    = ST_ITERM;
                state_next  = ST_MUL;
            end
            ST_ITERM: begin
                // Integral times the scaled integral gain.
                acc_next    = '0;
                mcand_next  = i_clamp;
                mplier_next = acc_reg[MQ_W-1:0];
                cnt_next    = CNT_W'(MQ_W);
                ret_next    = ST_ADDI;
                state_next  = ST_MUL;
            end
            ST_ADDI: begin
                p_next      = alu_res;
                // Derivative gain times the change in error.
                acc_next    = '0;
                mcand_next  = ACC_W'(diff_reg);
                mplier_next = {deriv_gain_reg, 8'd0};
                cnt_next    = CNT_W'(GAIN_W);
                ret_next    = ST_ADDD;
                state_next  = ST_MUL;
            end
            ST_ADDD: begin
                // Full PID sum times the nominal interval.
                acc_next    = '0;
                mcand_next  = alu_res;
                mplier_next = {nom, 16'd0};
                cnt_next    = CNT_W'(NOM_W);
                ret_next    = ST_PN;
                state_next  = ST_MUL;
            end
            ST_PN: begin
                pn_next     = acc_reg;
                // Gain sum, Horner form: (integ * nom + prop) * nom + deriv.
                acc_next    = '0;
                mcand_next  = ACC_W'(integ_gain_reg);
                mplier_next = {nom, 16'd0};
                cnt_next    = CNT_W'(NOM_W);
                ret_next    = ST_GP;
                state_next  = ST_MUL;
            end
            ST_GP: begin
                acc_next    = '0;
                mcand_next  = alu_res;
                mplier_next = {nom, 16'd0};
                cnt_next    = CNT_W'(NOM_W);
                ret_next    = ST_GD;
                state_next  = ST_MUL;
            end
            ST_GD: begin
                // Divisor: interval times gain sum.
                acc_next    = '0;
                mcand_next  = alu_res;
                mplier_next = {dt_reg, 16'd0};
                cnt_next    = CNT_W'(ELAPSED_W);
                ret_next    = ST_THR;
                state_next  = ST_MUL;
            end
            ST_THR: begin
                // Saturation threshold: divisor times the limit in Q8.8.
                acc_next    = '0;
                mcand_next  = acc_reg;
                mplier_next = {max_corr_reg, 8'd0, 9'd0};
                cnt_next    = CNT_W'(DIV_STEPS);
                ret_next    = ST_ABS;
                state_next  = ST_MUL;
            end
            ST_ABS: begin
                p_next   = acc_reg;
                neg_next = pn_reg[ACC_W-1];
                if (pn_reg[ACC_W-1]) begin
                    pn_next = alu_res;
                end
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (alu_res[ACC_W-1]) begin
                    // Past the bound: the output is the limit itself.
                    mplier_next = {9'd0, max_corr_reg, 8'd0};
                    state_next  = ST_OUT;
                end else begin
                    mcand_next  = mcand_reg <<< (DIV_STEPS - 1);
                    mplier_next = '0;
                    cnt_next    = CNT_W'(DIV_STEPS);
                    state_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!alu_res[ACC_W-1]) begin
                    pn_next = alu_res;
                end
                mplier_next = {mplier_reg[MQ_W-2:0], !alu_res[ACC_W-1]};
                mcand_next  = mcand_reg >>> 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    if (zero_gain) begin
                        out_data_next = '0;
                    end else if (neg_reg) begin
                        out_data_next = -q_mag;
                    end else begin
                        out_data_next = q_mag;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and stored controller state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            cnt_reg       <= '0;
            integ_sum_reg <= '0;
            prev_err_reg  <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cnt_reg       <= cnt_next;
            integ_sum_reg <= integ_sum_next;
            prev_err_reg  <= prev_err_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        p_reg        <= p_next;
        pn_reg       <= pn_next;
        neg_reg      <= neg_next;
        diff_reg     <= diff_next;
        dt_reg       <= dt_next;
        out_data_reg <= out_data_next;
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg    <= RST_PROP_GAIN;
            integ_gain_reg   <= RST_INTEG_GAIN;
            deriv_gain_reg   <= RST_DERIV_GAIN;
            max_corr_reg     <= RST_MAX_CORR;
            nom_interval_reg <= RST_NOM_INTERVAL;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PROP_GAIN:    prop_gain_reg    <= cfg_wdata;
                REG_INTEG_GAIN:   integ_gain_reg   <= cfg_wdata;
                REG_DERIV_GAIN:   deriv_gain_reg   <= cfg_wdata;
                REG_MAX_CORR:     max_corr_reg     <= cfg_wdata[MAXC_W-1:0];
                REG_NOM_INTERVAL: nom_interval_reg <= cfg_wdata[NOM_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* verif/tb.sv */
// Self-checking stream testbench for the roll correction PID core.
module tb;
    import prc_pkg::*;

    // Clocking, run limits and the sizes of the random part.
    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 4;
    localparam int CORE_LATENCY    = 160;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_CYCLES     = 1500;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int SETTING_BLOCKS  = 12;
    localparam int BLOCK_SAMPLES   = 112;
    localparam int DRIFT_LIMIT     = 46080;

    // Predictor arithmetic limits.
    localparam longint INTEG_MAX = (longint'(1) <<< (DEFAULT_INTEGRAL_WIDTH - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;
    localparam longint PROD_CAP  = longint'(1) <<< 62;

    typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_e;

    typedef struct packed {
        row_kind_e                 kind;
        logic [CFG_ADDR_W-1:0]     cfg_reg;
        logic [CFG_DATA_W-1:0]     cfg_val;
        logic signed [ANGLE_W-1:0] angle;
        logic [ELAPSED_W-1:0]      elapsed;
        logic                      has_fixed;
        logic signed [CORR_W-1:0]  fixed_corr;
    } stim_row_t;

    // Directed rows: extremes of the fields, the first sample after reset,
    // zero elapsed, zero nominal interval, all gains zero, a zero correction
    // limit and the most negative angle. A fixed correction is given only
    // where it is obvious; the rest go through the predictor.
    localparam int DIRECTED_ROWS = 27;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_SAMPLE, '0, '0, 17'sd0,      8'd0,   1'b1, 16'sd0},
        '{ROW_SAMPLE, '0, '0, ANGLE_MIN,   8'd0,   1'b1, 16'sd11520},
        '{ROW_SAMPLE, '0, '0, ERR_MAX,     8'd1,   1'b1, -16'sd11520},
        '{ROW_SAMPLE, '0, '0, 17'sd256,    8'd255, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, -17'sd256,   8'd17,  1'b0, '0},
        '{ROW_CONFIG, REG_PROP_GAIN,    16'd65535, '0, '0, 1'b0, '0},
        '{ROW_CONFIG, REG_INTEG_GAIN,   16'd65535, '0, '0, 1'b0, '0},
        '{ROW_CONFIG, REG_DERIV_GAIN,   16'd65535, '0, '0, 1'b0, '0},
        '{ROW_CONFIG, REG_MAX_CORR,     16'd127,   '0, '0, 1'b0, '0},
        '{ROW_CONFIG, REG_NOM_INTERVAL, 16'd255,   '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 17'sd46080,  8'd255, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, -17'sd46080, 8'd255, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 17'sd1,      8'd0,   1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 17'sd0,      8'd128, 1'b0, '0},
        '{ROW_CONFIG, REG_PROP_GAIN,    16'd0,     '0, '0, 1'b0, '0},
        '{ROW_CONFIG, REG_INTEG_GAIN,   16'd0,     '0, '0, 1'b0, '0},
        '{ROW_CONFIG, REG_DERIV_GAIN,   16'd0,     '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 17'sd12345,  8'd3,   1'b1, 16'sd0},
        '{ROW_SAMPLE, '0, '0, ANGLE_MIN,   8'd255, 1'b1, 16'sd0},
        '{ROW_CONFIG, REG_PROP_GAIN,    16'd100,   '0, '0, 1'b0, '0},
        '{ROW_CONFIG, REG_MAX_CORR,     16'd0,     '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, -17'sd20000, 8'd9,   1'b1, 16'sd0},
        '{ROW_CONFIG, REG_MAX_CORR,     16'd1,     '0, '0, 1'b0, '0},
        '{ROW_CONFIG, REG_NOM_INTERVAL, 16'd0,     '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 17'sd5000,   8'd0,   1'b0, '0},
        '{ROW_SAMPLE, '0, '0, -17'sd5000,  8'd0,   1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 17'sd300,    8'd7,   1'b0, '0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Fixed correction that travels alongside the current sample beat.
    logic                     row_has_fixed;
    logic signed [CORR_W-1:0] row_fixed_corr;

    // Copy of the controller registers and state.
    logic [GAIN_W-1:0] gain_p     = RST_PROP_GAIN;
    logic [GAIN_W-1:0] gain_i     = RST_INTEG_GAIN;
    logic [GAIN_W-1:0] gain_d     = RST_DERIV_GAIN;
    logic [MAXC_W-1:0] corr_limit = RST_MAX_CORR;
    logic [NOM_W-1:0]  nom_ticks  = RST_NOM_INTERVAL;
    longint            integ_acc  = 0;
    longint            last_err   = 0;
    bit                seen_first = 1'b0;

    logic signed [CORR_W-1:0] pending_corrections [$];
    logic signed [CORR_W-1:0] predicted_corr;

    int samples_accepted    = 0;
    int corrections_checked = 0;
    int bound_hits          = 0;
    int register_writes     = 0;
    int mismatches          = 0;
    int quiet_cycles        = 0;

    // Idling controls, written only by the stimulus process.
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;

    pid_roll_correction_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Product of a signed value and a non-negative one, clamped at 2^62.
    function automatic longint clamped_product(input longint a, input longint b);
        longint unsigned mag;
        if (b <= 0 || a == 0) return 0;
        mag = (a < 0) ? longint'(0) - a : a;
        if (mag > longint'(PROD_CAP) / b) return (a < 0) ? -PROD_CAP : PROD_CAP;
        return (a < 0) ? -longint'(mag * b) : longint'(mag * b);
    endfunction

    // Advances the controller state by one sample and returns its correction.
    function automatic logic signed [CORR_W-1:0] roll_correction(
        input logic signed [ANGLE_W-1:0] angle,
        input logic [ELAPSED_W-1:0] elapsed
    );
        longint err, dt, nom, delta, pid_sum, gain_sum, scaled, thresh, lim, res;
        lim = longint'(corr_limit) * 256;
        err = -longint'(angle);
        if (err > 65535) err = 65535;
        nom = (nom_ticks != 0) ? longint'(nom_ticks) : 1;
        dt = longint'(elapsed);
        if (!seen_first) begin
            dt = nom;
            seen_first = 1'b1;
        end
        if (dt == 0) dt = 1;

        // Integral with saturation at the integral width.
        delta = err * dt;
        if (delta > 0 && integ_acc > INTEG_MAX - delta) integ_acc = INTEG_MAX;
        else if (delta < 0 && integ_acc < INTEG_MIN - delta) integ_acc = INTEG_MIN;
        else integ_acc += delta;

        pid_sum = longint'(gain_p) * err * dt
                + clamped_product(integ_acc, longint'(gain_i) * dt)
                + longint'(gain_d) * (err - last_err);
        last_err = err;

        // Scale so that the gain bound maps onto the correction limit.
        gain_sum = longint'(gain_p) * nom + longint'(gain_i) * nom * nom
                 + longint'(gain_d);
        if (gain_sum == 0) begin
            res = 0;
        end else begin
            scaled = clamped_product(pid_sum, nom);
            thresh = lim * dt * gain_sum;
            if (scaled > thresh) res = lim;
            else if (scaled < -thresh) res = -lim;
            else res = scaled / (dt * gain_sum);
        end
        return res[CORR_W-1:0];
    endfunction

    function automatic void apply_register(
        input logic [CFG_ADDR_W-1:0] addr,
        input logic [CFG_DATA_W-1:0] data
    );
        case (addr)
            REG_PROP_GAIN:    gain_p = data[GAIN_W-1:0];
            REG_INTEG_GAIN:   gain_i = data[GAIN_W-1:0];
            REG_DERIV_GAIN:   gain_d = data[GAIN_W-1:0];
            REG_MAX_CORR:     corr_limit = data[MAXC_W-1:0];
            REG_NOM_INTERVAL: nom_ticks = data[NOM_W-1:0];
            default: ;
        endcase
    endfunction

    // Scoreboard: register writes, correction checks and sample predictions,
    // all taken at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                apply_register(cfg_addr, cfg_wdata);
                register_writes++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_corrections.size() == 0) begin
                    $display("%0t: correction %0d arrived with nothing expected",
                             $time, $signed(m_tdata[CORR_W-1:0]));
                    mismatches++;
                end else begin
                    predicted_corr = pending_corrections.pop_front();
                    if (m_tdata[CORR_W-1:0] !== predicted_corr) begin
                        $display("%0t: correction mismatch: expected %0d, got %0d",
                                 $time, predicted_corr, $signed(m_tdata[CORR_W-1:0]));
                        mismatches++;
                    end
                    if (predicted_corr == corr_limit * 256 ||
                        predicted_corr == -(corr_limit * 256))
                        bound_hits++;
                    corrections_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                predicted_corr = roll_correction($signed(s_tdata[ANGLE_W-1:0]),
                                                 s_tdata[ANGLE_W +: ELAPSED_W]);
                pending_corrections.push_back(row_has_fixed ? row_fixed_corr
                                                            : predicted_corr);
                samples_accepted++;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    int hold_left = 0;
    int hold_seen = 0;
    always @(negedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Watchdog: ends the run when no beat and no write happens for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb failed");
            $finish;
        end
    end

    // Offers one sample beat after a random gap and holds it until taken.
    task automatic drive_sample(
        input logic signed [ANGLE_W-1:0] angle,
        input logic [ELAPSED_W-1:0] elapsed,
        input logic has_fixed,
        input logic signed [CORR_W-1:0] fixed_corr
    );
        int gap;
        gap = 0;
        if (tx_idle_pct != 0 && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 200);
        while (gap > 0 || $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= $urandom();
            if (gap > 0) gap--;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_DATA_W - ANGLE_W - ELAPSED_W){1'b0}}, elapsed, angle};
        row_has_fixed <= has_fixed;
        row_fixed_corr <= fixed_corr;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stops offering samples and waits until every correction has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_corrections.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(
        input logic [CFG_ADDR_W-1:0] addr,
        input logic [CFG_DATA_W-1:0] data
    );
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_settings(
        input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
        input logic [GAIN_W-1:0] d, input logic [MAXC_W-1:0] mc,
        input logic [NOM_W-1:0] nom
    );
        write_register(REG_PROP_GAIN, p);
        write_register(REG_INTEG_GAIN, i);
        write_register(REG_DERIV_GAIN, d);
        write_register(REG_MAX_CORR, CFG_DATA_W'(mc));
        write_register(REG_NOM_INTERVAL, CFG_DATA_W'(nom));
    endtask

    // Changes the idling mix away from the falling edge, where it is read.
    task automatic set_idling(input int tx_pct, input int rx_pct, input bit hold);
        @(posedge aclk);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        if (hold) hold_requests++;
        @(negedge aclk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4, 5: return GAIN_W'($urandom_range(0, 64));
            6, 7, 8: return GAIN_W'($urandom_range(0, 4000));
            default: return GAIN_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [MAXC_W-1:0] pick_limit();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 7'd127;
            2: return 7'd90;
            3: return 7'd1;
            default: return MAXC_W'($urandom_range(1, 90));
        endcase
    endfunction

    function automatic logic [NOM_W-1:0] pick_nominal();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 8'd255;
            2: return 8'd1;
            default: return NOM_W'($urandom_range(1, 20));
        endcase
    endfunction

    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return 8'd255;
            2, 3: return ELAPSED_W'($urandom_range(0, 255));
            default: return ELAPSED_W'($urandom_range(1, 10));
        endcase
    endfunction

    // Stimulus: reset, directed rows, then random blocks of samples.
    initial begin
        int drift;
        int tx_pct;
        int rx_pct;
        logic signed [ANGLE_W-1:0] angle;

        drift = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        row_has_fixed = 1'b0;
        row_fixed_corr = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, no idling.
        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_CONFIG) begin
                wait_idle();
                write_register(DIRECTED[r].cfg_reg, DIRECTED[r].cfg_val);
            end else begin
                drive_sample(DIRECTED[r].angle, DIRECTED[r].elapsed,
                             DIRECTED[r].has_fixed, DIRECTED[r].fixed_corr);
            end
        end

        // Random part: each block drains, loads a setting and runs a mix of
        // slowly drifting attitudes and full-range noise samples.
        for (int blk = 0; blk < SETTING_BLOCKS; blk++) begin
            wait_idle();
            if (blk == 0)
                write_settings(RST_PROP_GAIN, RST_INTEG_GAIN, RST_DERIV_GAIN,
                               RST_MAX_CORR, RST_NOM_INTERVAL);
            else if (blk == SETTING_BLOCKS - 1)
                write_settings('1, '0, '1, 7'd90, 8'd1);
            else
                write_settings(pick_gain(), pick_gain(), pick_gain(), pick_limit(),
                               pick_nominal());

            case (blk / 3)
                0: begin tx_pct = 0;  rx_pct = 0;  end
                1: begin tx_pct = 72; rx_pct = 0;  end
                2: begin tx_pct = 0;  rx_pct = 72; end
                default: begin tx_pct = 33; rx_pct = 33; end
            endcase
            // One block starts with a long receiver hold-off so that the
            // core backs up and stalls its input.
            set_idling(tx_pct, rx_pct, blk == 1);

            for (int n = 0; n < BLOCK_SAMPLES; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    angle = ANGLE_W'($urandom_range(0, 131071));
                end else begin
                    drift = drift - drift / 16 + int'($urandom_range(0, 1200)) - 600;
                    if (drift > DRIFT_LIMIT) drift = DRIFT_LIMIT;
                    if (drift < -DRIFT_LIMIT) drift = -DRIFT_LIMIT;
                    angle = ANGLE_W'(drift);
                end
                drive_sample(angle, pick_elapsed(), 1'b0, '0);
            end
        end

        // Drain and give the core time to show any stray beat.
        wait_idle();
        repeat (CORE_LATENCY) @(negedge aclk);

        $display("Sent %0d samples through directed rows and %0d random settings,",
                 samples_accepted, SETTING_BLOCKS);
        $display("with four idle mixes and a long output hold-off; %0d corrections %s%0d",
                 corrections_checked, "checked, at the bound: ", bound_hits);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

/* filelist.f */
src/prc_pkg.sv
src/pid_roll_correction_core.sv
verif/tb.sv
